/* hdl/sbq_pkg.sv */
`timescale 1ns / 1ps

package sbq_pkg;

   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int STATE_W    = 40;
   localparam int STATE_FRAC = SAMPLE_W + 7;
   localparam int PROD_SHIFT = COEF_W - 10;
   localparam int OUT_SHIFT  = STATE_FRAC - (SAMPLE_W - 1);

   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int RND_W  = PROD_W - PROD_SHIFT;
   localparam int SUM_W  = STATE_W + 2;
   localparam int YR_W   = STATE_W + 1 - OUT_SHIFT;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_B0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MONO = 3'd5;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << (COEF_W - 2));

   localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'd1 << (PROD_SHIFT - 1));
   localparam logic signed [STATE_W:0] OUT_HALF = (STATE_W + 1)'(64'd1 << (OUT_SHIFT - 1));

   localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W - 1){1'b1}}};
   localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W - 1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   // one strobe per lane step, driven by the sequencer in the top level
   typedef struct packed {
      logic load_x;
      logic mul_x;
      logic rnd_x;
      logic sum_y;
      logic out_y;
      logic mul_y;
      logic rnd_y;
      logic update;
   } lane_ctrl_type;

   // round half up then arithmetic shift right
   function automatic logic signed [RND_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_HALF;
      return t[PROD_W-1:PROD_SHIFT];
   endfunction

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-STATE_W:0] top;
      top = v[SUM_W-1:STATE_W-1];
      if (top == '0 || top == '1) begin
         return v[STATE_W-1:0];
      end
      return v[SUM_W-1] ? STATE_MIN : STATE_MAX;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] round_sat_out(
      input logic signed [STATE_W-1:0] yw);
      logic signed [STATE_W:0] t;
      logic signed [YR_W-1:0]  r;
      logic [YR_W-SAMPLE_W:0]  top;
      t   = (STATE_W + 1)'(yw) + OUT_HALF;
      r   = t[STATE_W:OUT_SHIFT];
      top = r[YR_W-1:SAMPLE_W-1];
      if (top == '0 || top == '1) begin
         return r[SAMPLE_W-1:0];
      end
      return r[YR_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
   endfunction

endpackage

/* hdl/sbq_req_if.sv */
`timescale 1ns / 1ps

interface sbq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sbq_pkg::SAMPLE_W-1:0]    left_in;
   logic signed [sbq_pkg::SAMPLE_W-1:0]    right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink (input valid, input left_in, input right_in, output ready);
endinterface

/* hdl/sbq_rsp_if.sv */
`timescale 1ns / 1ps

interface sbq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sbq_pkg::SAMPLE_W-1:0]    left_out;
   logic signed [sbq_pkg::SAMPLE_W-1:0]    right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink (input valid, input left_out, input right_out, output ready);
endinterface

/* hdl/sbq_lane.sv */
`timescale 1ns / 1ps

module sbq_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sbq_pkg::lane_ctrl_type               ctrl,
   input  sbq_pkg::coef_type                    coef,
   input  logic signed [sbq_pkg::SAMPLE_W-1:0]  x_in,
   output logic signed [sbq_pkg::SAMPLE_W-1:0]  y_out
);

   logic signed [sbq_pkg::SAMPLE_W-1:0] x_ff;
   logic signed [sbq_pkg::PROD_W-1:0]   pb0_ff, pb1_ff, pb2_ff;
   logic signed [sbq_pkg::RND_W-1:0]    rb0_ff, rb1_ff, rb2_ff;
   logic signed [sbq_pkg::STATE_W-1:0]  yw_ff;
   logic signed [sbq_pkg::SUM_W-1:0]    q1_ff, q2_ff;
   logic signed [sbq_pkg::SAMPLE_W-1:0] y_ff;
   logic signed [sbq_pkg::PROD_W-1:0]   pa1_ff, pa2_ff;
   logic signed [sbq_pkg::RND_W-1:0]    ra1_ff, ra2_ff;
   logic signed [sbq_pkg::STATE_W-1:0]  d1_ff, d2_ff;

   logic signed [sbq_pkg::SUM_W-1:0]    yw_sum;
   logic signed [sbq_pkg::SUM_W-1:0]    n1_sum, n2_sum;

   always_comb begin
      yw_sum = sbq_pkg::SUM_W'(rb0_ff) + sbq_pkg::SUM_W'(d1_ff);
      n1_sum = q1_ff - sbq_pkg::SUM_W'(ra1_ff);
      n2_sum = q2_ff - sbq_pkg::SUM_W'(ra2_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_x) begin
         x_ff <= x_in;
      end
      if (ctrl.mul_x) begin
         pb0_ff <= sbq_pkg::PROD_W'(coef.b0) * sbq_pkg::PROD_W'(x_ff);
         pb1_ff <= sbq_pkg::PROD_W'(coef.b1) * sbq_pkg::PROD_W'(x_ff);
         pb2_ff <= sbq_pkg::PROD_W'(coef.b2) * sbq_pkg::PROD_W'(x_ff);
      end
      if (ctrl.rnd_x) begin
         rb0_ff <= sbq_pkg::round_prod(pb0_ff);
         rb1_ff <= sbq_pkg::round_prod(pb1_ff);
         rb2_ff <= sbq_pkg::round_prod(pb2_ff);
      end
      if (ctrl.sum_y) begin
         yw_ff <= sbq_pkg::sat_state(yw_sum);
         q1_ff <= sbq_pkg::SUM_W'(rb1_ff) + sbq_pkg::SUM_W'(d2_ff);
         q2_ff <= sbq_pkg::SUM_W'(rb2_ff);
      end
      if (ctrl.out_y) begin
         y_ff <= sbq_pkg::round_sat_out(yw_ff);
      end
      // feedback uses the saturated output sample
      if (ctrl.mul_y) begin
         pa1_ff <= sbq_pkg::PROD_W'(coef.a1) * sbq_pkg::PROD_W'(y_ff);
         pa2_ff <= sbq_pkg::PROD_W'(coef.a2) * sbq_pkg::PROD_W'(y_ff);
      end
      if (ctrl.rnd_y) begin
         ra1_ff <= sbq_pkg::round_prod(pa1_ff);
         ra2_ff <= sbq_pkg::round_prod(pa2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else if (ctrl.update) begin
         d1_ff <= sbq_pkg::sat_state(n1_sum);
         d2_ff <= sbq_pkg::sat_state(n2_sum);
      end
   end

   assign y_out = y_ff;

endmodule

/* hdl/sbq_merge.sv */
`timescale 1ns / 1ps

module sbq_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [sbq_pkg::SAMPLE_W-1:0]  left_y,
   input  logic signed [sbq_pkg::SAMPLE_W-1:0]  right_y,
   output logic                                 free,
   sbq_rsp_if.source                            rsp
);

   logic                                valid_ff, valid_in;
   logic signed [sbq_pkg::SAMPLE_W-1:0] left_ff, right_ff;

   // slot can take a new word when empty or being drained this cycle
   assign free = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_y;
         right_ff <= right_y;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.left_out  = left_ff;
   assign rsp.right_out = right_ff;

endmodule

/* hdl/stereo_biquad_filter_df2t.sv */
`timescale 1ns / 1ps

// Stereo biquad filter, transposed direct form II, shared coefficients.
// req channel: one word carries a left and a right Q1.23 sample. rsp
// channel: one word with both filtered samples, Q1.23, rounded and saturated.
// Coefficients (Q2.30) and the mono flag are written through the csr port,
// one register per write; the user must write them only while no word is
// in flight, as the block itself does not enforce it. Two identical lanes,
// one per channel, run the same step sequence; an output register joins
// their results into one rsp word. rsp.valid rises when the update step
// loads the output register. A new req word is taken only after the last
// one has passed the per-channel chain of input multiply, round, sum, output
// rounding, feedback multiply, round and state update; req.ready is high
// only between words. If the receiver stalls, the finished word waits in
// the output register while the next req word is taken and worked on; its
// update step waits until the output register is free.
// Reset (synchronous): state words cleared, b0 = 1.0, other coefficients
// zero, mono off, output register empty.
module stereo_biquad_filter_df2t (
   input  logic                                clock,
   input  logic                                reset,
   sbq_req_if.sink                             req,
   sbq_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  logic [sbq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sbq_pkg::COEF_W-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_X,
      ST_RND_X,
      ST_SUM_Y,
      ST_OUT_Y,
      ST_MUL_Y,
      ST_RND_Y,
      ST_UPDATE
   } state_type;

   state_type                           state_ff, state_in;
   sbq_pkg::coef_type                   coef_ff;
   logic                                mono_ff;
   sbq_pkg::lane_ctrl_type              ctrl;
   logic                                out_free;
   logic                                accept;
   logic signed [sbq_pkg::SAMPLE_W-1:0] right_x;
   logic signed [sbq_pkg::SAMPLE_W-1:0] left_y, right_y;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0 <= sbq_pkg::COEF_ONE;
         coef_ff.b1 <= '0;
         coef_ff.b2 <= '0;
         coef_ff.a1 <= '0;
         coef_ff.a2 <= '0;
         mono_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            sbq_pkg::CSR_B0:   coef_ff.b0 <= csr_wdata;
            sbq_pkg::CSR_B1:   coef_ff.b1 <= csr_wdata;
            sbq_pkg::CSR_B2:   coef_ff.b2 <= csr_wdata;
            sbq_pkg::CSR_A1:   coef_ff.a1 <= csr_wdata;
            sbq_pkg::CSR_A2:   coef_ff.a2 <= csr_wdata;
            sbq_pkg::CSR_MONO: mono_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign right_x   = mono_ff ? req.left_in : req.right_in;

   always_comb begin
      ctrl        = '0;
      ctrl.load_x = accept;
      ctrl.mul_x  = (state_ff == ST_MUL_X);
      ctrl.rnd_x  = (state_ff == ST_RND_X);
      ctrl.sum_y  = (state_ff == ST_SUM_Y);
      ctrl.out_y  = (state_ff == ST_OUT_Y);
      ctrl.mul_y  = (state_ff == ST_MUL_Y);
      ctrl.rnd_y  = (state_ff == ST_RND_Y);
      ctrl.update = (state_ff == ST_UPDATE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_RND_X;
         ST_RND_X:  state_in = ST_SUM_Y;
         ST_SUM_Y:  state_in = ST_OUT_Y;
         ST_OUT_Y:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_RND_Y;
         ST_RND_Y:  state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   sbq_lane u_lane_left (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .coef  (coef_ff),
      .x_in  (req.left_in),
      .y_out (left_y)
   );

   sbq_lane u_lane_right (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .coef  (coef_ff),
      .x_in  (right_x),
      .y_out (right_y)
   );

   sbq_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .load    (ctrl.update),
      .left_y  (left_y),
      .right_y (right_y),
      .free    (out_free),
      .rsp     (rsp)
   );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

   typedef logic signed [sbq_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

   typedef struct packed {
      int set_sel;
      bit mono;
      int left;
      int right;
      bit typed;
      int exp_left;
      int exp_right;
   } dir_row_type;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int QUIET_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 200;
   localparam int HOLD_PHASE   = 4;
   localparam int PAUSE_PHASE  = 5;

   localparam logic [sbq_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [sbq_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic signed [sbq_pkg::COEF_W-1:0] COEF_TOP =
      {1'b0, {(sbq_pkg::COEF_W - 1){1'b1}}};
   localparam logic signed [sbq_pkg::COEF_W-1:0] COEF_BOT =
      {1'b1, {(sbq_pkg::COEF_W - 1){1'b0}}};

   localparam int STYLE_WIDE   = 0;
   localparam int STYLE_AUDIO  = 1;
   localparam int STYLE_CORNER = 2;

   localparam int SET_KEEP       = -1;
   localparam int SET_GAIN_NEG2  = 0;
   localparam int SET_MONO_UNITY = 1;
   localparam int SET_ALL_TOP    = 2;
   localparam int SET_ALL_BOT    = 3;
   localparam int SET_RESONANT   = 4;

   localparam sbq_pkg::coef_type DIR_SETS [5] = '{
      '{COEF_BOT, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{sbq_pkg::COEF_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP, COEF_TOP},
      '{COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT, COEF_BOT},
      // narrow low-pass with poles close to the unit circle
      '{32'sh00A3_D70A, 32'sh0147_AE14, 32'sh00A3_D70A, 32'sh8CCC_CCCD, 32'sh33D7_0A3D}
   };

   localparam int DIR_COUNT = 21;
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      // unity gain after reset: words pass straight through
      '{SET_KEEP, 1'b0, 8388607, -8388608, 1'b1, 8388607, -8388608},
      '{SET_KEEP, 1'b0, -8388608, 8388607, 1'b1, -8388608, 8388607},
      '{SET_KEEP, 1'b0, 0, -1, 1'b1, 0, -1},
      '{SET_KEEP, 1'b0, 5592405, -5592406, 1'b1, 5592405, -5592406},
      // gain of -2.0 saturates the full-scale inputs
      '{SET_GAIN_NEG2, 1'b0, 8388607, -8388608, 1'b1, -8388608, 8388607},
      '{SET_KEEP, 1'b0, -1, 1, 1'b1, 2, -2},
      '{SET_KEEP, 1'b0, 0, 8388607, 1'b1, 0, -8388608},
      // mono: right copies left
      '{SET_MONO_UNITY, 1'b1, -8388608, 8388607, 1'b1, -8388608, -8388608},
      '{SET_KEEP, 1'b1, 1234567, -7654321, 1'b1, 1234567, 1234567},
      // saturated outputs feed back through the a terms
      '{SET_ALL_TOP, 1'b0, 8388607, -8388608, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 8388607, -8388608, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, -8388608, 8388607, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 0, 0, 1'b0, 0, 0},
      '{SET_ALL_BOT, 1'b1, -8388608, 8388607, 1'b0, 0, 0},
      '{SET_KEEP, 1'b1, 8388607, 0, 1'b0, 0, 0},
      '{SET_KEEP, 1'b1, -8388608, -8388608, 1'b0, 0, 0},
      // new coefficients on top of the old state, then the ringing
      '{SET_RESONANT, 1'b0, 8388607, -8388608, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 0, 0, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 0, 0, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 0, 0, 1'b0, 0, 0},
      '{SET_KEEP, 1'b0, 0, 0, 1'b0, 0, 0}
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [sbq_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sbq_pkg::COEF_W-1:0] csr_wdata;

   sbq_req_if req_if ();
   sbq_rsp_if rsp_if ();

   stereo_biquad_filter_df2t dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // filter state and settings as the block should hold them
   sbq_pkg::coef_type coefs;
   bit       mono_on;
   longint   dly_one [2];
   longint   dly_two [2];

   frame_type filtered_q [$];
   frame_type want;
   int mismatch_count = 0;
   int cycle_count = 0;
   int src_idle_pct = 0;
   int snk_stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // add half an lsb, then shift right arithmetically
   function automatic longint rshift_round(input longint v, input int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic longint coef_mul(input logic signed [sbq_pkg::COEF_W-1:0] c,
                                       input longint x);
      return rshift_round(longint'(c) * x, sbq_pkg::PROD_SHIFT);
   endfunction

   function automatic sample_type filter_lane(input int ch, input sample_type x);
      longint xs;
      longint yw;
      longint y;
      longint n1;
      longint n2;
      xs = x;
      yw = clip(coef_mul(coefs.b0, xs) + dly_one[ch], sbq_pkg::STATE_W);
      y  = clip(rshift_round(yw, sbq_pkg::OUT_SHIFT), sbq_pkg::SAMPLE_W);
      // feedback uses the saturated output sample
      n1 = coef_mul(coefs.b1, xs) - coef_mul(coefs.a1, y) + dly_two[ch];
      n2 = coef_mul(coefs.b2, xs) - coef_mul(coefs.a2, y);
      dly_one[ch] = clip(n1, sbq_pkg::STATE_W);
      dly_two[ch] = clip(n2, sbq_pkg::STATE_W);
      return sample_type'(y);
   endfunction

   function automatic frame_type filter_frame(input sample_type l, input sample_type r);
      frame_type f;
      f.left  = filter_lane(0, l);
      f.right = filter_lane(1, mono_on ? l : r);
      return f;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? sbq_pkg::SAMPLE_MAX : sbq_pkg::SAMPLE_MIN;
         1: return sample_type'($signed($urandom_range(511)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic signed [sbq_pkg::COEF_W-1:0] pick_coef(input int style);
      case (style)
         STYLE_AUDIO: begin
            return sbq_pkg::COEF_W'(int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
         end
         STYLE_CORNER: begin
            case ($urandom_range(4))
               0: return COEF_TOP;
               1: return COEF_BOT;
               2: return '0;
               3: return sbq_pkg::COEF_ONE;
               default: return -sbq_pkg::COEF_ONE;
            endcase
         end
         default: return sbq_pkg::COEF_W'($urandom);
      endcase
   endfunction

   task automatic flag_error(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   task automatic csr_put(input logic [sbq_pkg::CSR_IDX_W-1:0] idx,
                          input logic [sbq_pkg::COEF_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic load_filter(input sbq_pkg::coef_type c, input bit mono);
      csr_put(sbq_pkg::CSR_B0, c.b0);
      csr_put(sbq_pkg::CSR_B1, c.b1);
      csr_put(sbq_pkg::CSR_B2, c.b2);
      csr_put(CSR_SPARE_LO, $urandom);
      csr_put(sbq_pkg::CSR_A1, c.a1);
      csr_put(sbq_pkg::CSR_A2, c.a2);
      // junk above bit 0 must be dropped
      csr_put(sbq_pkg::CSR_MONO, {31'($urandom), mono});
      csr_put(CSR_SPARE_HI, $urandom);
      csr_we  <= 1'b0;
      coefs   = c;
      mono_on = mono;
   endtask

   // hold the sender until every word is back, optionally let the pipe go quiet
   task automatic settle(input bit quiet);
      req_if.valid <= 1'b0;
      do @(negedge clock); while (filtered_q.size() != 0);
      if (quiet) begin
         repeat (QUIET_CYCLES) @(negedge clock);
      end
   endtask

   task automatic send_word(input sample_type l, input sample_type r, input bit typed,
                            input frame_type typed_exp);
      frame_type predicted;
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.left_in  <= l;
      req_if.right_in <= r;
      do @(posedge clock); while (!req_if.ready);
      predicted = filter_frame(l, r);
      filtered_q.push_back(typed ? typed_exp : predicted);
      @(negedge clock);
   endtask

   // receiver: random stalls plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (filtered_q.size() == 0) begin
            flag_error($sformatf("word with nothing expected: left %0d right %0d",
                                 rsp_if.left_out, rsp_if.right_out));
         end else begin
            want = filtered_q.pop_front();
            if (rsp_if.left_out !== want.left) begin
               flag_error($sformatf("left_out: expected %0d, got %0d",
                                    want.left, rsp_if.left_out));
            end
            if (rsp_if.right_out !== want.right) begin
               flag_error($sformatf("right_out: expected %0d, got %0d",
                                    want.right, rsp_if.right_out));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      dir_row_type       row;
      frame_type         tex;
      sbq_pkg::coef_type cf;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_if.valid    = 1'b0;
      req_if.left_in  = '0;
      req_if.right_in = '0;
      coefs           = '0;
      coefs.b0        = sbq_pkg::COEF_ONE;
      mono_on         = 1'b0;
      dly_one         = '{0, 0};
      dly_two         = '{0, 0};

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_COUNT; i++) begin
         row = DIR_ROWS[i];
         if (row.set_sel != SET_KEEP) begin
            settle(1'b1);
            load_filter(DIR_SETS[row.set_sel], row.mono);
         end
         tex.left  = sample_type'(row.exp_left);
         tex.right = sample_type'(row.exp_right);
         send_word(sample_type'(row.left), sample_type'(row.right), row.typed, tex);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle(1'b1);
         case (ph % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
            default: begin src_idle_pct = 8; snk_stall_pct = 8; end
         endcase
         cf.b0 = pick_coef(ph % 3);
         cf.b1 = pick_coef(ph % 3);
         cf.b2 = pick_coef(ph % 3);
         cf.a1 = pick_coef(ph % 3);
         cf.a2 = pick_coef(ph % 3);
         load_filter(cf, ph[0]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // sender keeps offering while the receiver is held off
            if (ph == HOLD_PHASE && n == 40) begin
               hold_asked++;
            end
            if (ph == PAUSE_PHASE && n == 100) begin
               settle(1'b0);
            end
            send_word(rand_sample(), rand_sample(), 1'b0, '0);
         end
      end

      settle(1'b1);
      if (mismatch_count == 0 && filtered_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
